// ===== design/gcd_pkg.sv =====
`default_nettype none

package gcd_pkg;

   localparam int CORDIC_STEPS = 32;
   localparam int FRAC_BITS    = 30;
   localparam int CW           = 34;   // CORDIC datapath width
   localparam int AW           = 35;   // angle width, units of 0.5e-7 degree
   localparam int DIV_LAT      = 4;    // stages of the degree to radian divide
   localparam int SQRT_STEPS   = 31;   // root bits of the integer square root

   localparam int SC_LAT   = 4 + DIV_LAT + CORDIC_STEPS;
   localparam int ARC_LAT  = SQRT_STEPS + CORDIC_STEPS + 1;
   localparam int PIPE_LAT = 2 + SC_LAT + 4 + ARC_LAT + 1;

   localparam logic signed [AW-1:0] TURN_DEG7  = 35'sd3600000000;
   localparam logic signed [AW-1:0] TURN_HU    = 35'sd7200000000;
   localparam logic signed [AW-1:0] HALF_HU    = 35'sd3600000000;
   localparam logic signed [AW-1:0] QUARTER_HU = 35'sd1800000000;

   // rad = (mag * RAD_MUL + RAD_BIAS) / RAD_DEN, pi/180 scaling with halved terms
   localparam logic [30:0] RAD_MUL  = 31'd1686629713;
   localparam logic [61:0] RAD_BIAS = 62'd900000000;
   localparam logic [61:0] RAD_DEN  = 62'd1800000000;
   // RAD_MUL / RAD_DEN in 0.32 fixed point, estimate is off by at most one
   localparam logic [31:0] RAD_RCP  = 32'd4024455254;

   localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
   localparam logic [26:0] SCALE_2R  = 27'd127420000;
   localparam logic [27:0] DIST_MAX  = 28'd200151310;
   localparam logic [30:0] ONE_Q     = 31'h4000_0000;

   function automatic logic signed [CW-1:0] atan_q(input int i);
      logic signed [CW-1:0] r;
      case (i)
         0:  r = 34'sh3243F6A8;
         1:  r = 34'sh1DAC6705;
         2:  r = 34'sh0FADBAFC;
         3:  r = 34'sh07F56EA6;
         4:  r = 34'sh03FEAB76;
         5:  r = 34'sh01FFD55B;
         6:  r = 34'sh00FFFAAA;
         7:  r = 34'sh007FFF55;
         8:  r = 34'sh003FFFEA;
         9:  r = 34'sh001FFFFD;
         10: r = 34'sh000FFFFF;
         default: begin
            if (i < 30) r = (34'sd1 <<< (30 - i)) - 34'sd1;
            else        r = '0;
         end
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== design/gcd_sincos.sv =====
`default_nettype none

module gcd_sincos (
   input  wire logic                      clock,
   input  wire logic                      adv,
   input  wire logic [32:0]               u_in,
   output logic signed [gcd_pkg::CW-1:0]  sin_out,
   output logic signed [gcd_pkg::CW-1:0]  cos_out
);
   import gcd_pkg::*;

   // fold to +-90 degrees
   logic signed [AW-1:0] s1_ff, s1_in;
   logic [30:0]          mag_ff, mag_in;
   logic                 zneg_ff, zneg_in, ncb_ff, ncb_in;
   logic signed [AW-1:0] mag_w;

   always_comb begin
      if ($signed({2'b00, u_in}) > HALF_HU) s1_in = $signed({2'b00, u_in}) - TURN_HU;
      else                                  s1_in = $signed({2'b00, u_in});
   end

   always_comb begin
      if (s1_ff > QUARTER_HU)       mag_w = HALF_HU - s1_ff;
      else if (s1_ff < -QUARTER_HU) mag_w = HALF_HU + s1_ff;
      else if (s1_ff[AW-1])         mag_w = -s1_ff;
      else                          mag_w = s1_ff;
      mag_in  = mag_w[30:0];
      zneg_in = s1_ff[AW-1];
      ncb_in  = (s1_ff > QUARTER_HU) || (s1_ff < -QUARTER_HU);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff   <= s1_in;
         mag_ff  <= mag_in;
         zneg_ff <= zneg_in;
         ncb_ff  <= ncb_in;
      end
   end

   // divide by the constant: reciprocal estimate, product back, one-step fix
   logic [61:0]        num_in, num0_ff, num1_ff, num2_ff;
   logic [62:0]        est_in, est_ff;
   logic [30:0]        q0_in, q0_ff, q0d_ff, q_in, q_ff;
   logic [61:0]        qd_in, qd_ff;
   logic               dneg_ff [0:DIV_LAT-1];
   logic               dnc_ff  [0:DIV_LAT-1];
   logic signed [63:0] rem_w;

   assign num_in = 62'(mag_ff) * 62'(RAD_MUL) + RAD_BIAS;
   assign est_in = 63'(mag_ff) * 63'(RAD_RCP) + (63'd1 << 31);
   assign q0_in  = est_ff[62:32];
   assign qd_in  = 62'(q0_ff) * RAD_DEN;

   always_comb begin
      rem_w = $signed({2'b00, num2_ff}) - $signed({2'b00, qd_ff});
      if (rem_w[63])                              q_in = q0d_ff - 31'd1;
      else if (rem_w >= $signed({2'b00, RAD_DEN})) q_in = q0d_ff + 31'd1;
      else                                        q_in = q0d_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num0_ff    <= num_in;
         est_ff     <= est_in;
         dneg_ff[0] <= zneg_ff;
         dnc_ff[0]  <= ncb_ff;
         q0_ff      <= q0_in;
         num1_ff    <= num0_ff;
         dneg_ff[1] <= dneg_ff[0];
         dnc_ff[1]  <= dnc_ff[0];
         qd_ff      <= qd_in;
         q0d_ff     <= q0_ff;
         num2_ff    <= num1_ff;
         dneg_ff[2] <= dneg_ff[1];
         dnc_ff[2]  <= dnc_ff[1];
         q_ff       <= q_in;
         dneg_ff[3] <= dneg_ff[2];
         dnc_ff[3]  <= dnc_ff[2];
      end
   end

   // signed angle in Q30
   logic signed [CW-1:0] z0_ff, z0_in;
   logic                 znc_ff;

   always_comb begin
      if (dneg_ff[DIV_LAT-1]) z0_in = -$signed(CW'(q_ff));
      else                    z0_in = $signed(CW'(q_ff));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         z0_ff  <= z0_in;
         znc_ff <= dnc_ff[DIV_LAT-1];
      end
   end

   // rotation CORDIC, one iteration per stage
   logic signed [CW-1:0] x_ff  [0:CORDIC_STEPS-1];
   logic signed [CW-1:0] y_ff  [0:CORDIC_STEPS-1];
   logic signed [CW-1:0] z_ff  [0:CORDIC_STEPS-1];
   logic                 nc_ff [0:CORDIC_STEPS-1];

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      localparam logic signed [CW-1:0] AT = atan_q(i);
      logic signed [CW-1:0] xp, yp, zp, x_in, y_in, z_in;
      logic                 ncp;

      if (i == 0) begin : g_first
         assign xp  = GAIN_Q30;
         assign yp  = '0;
         assign zp  = z0_ff;
         assign ncp = znc_ff;
      end else begin : g_next
         assign xp  = x_ff[i-1];
         assign yp  = y_ff[i-1];
         assign zp  = z_ff[i-1];
         assign ncp = nc_ff[i-1];
      end

      always_comb begin
         if (!zp[CW-1]) begin
            x_in = xp - (yp >>> i);
            y_in = yp + (xp >>> i);
            z_in = zp - AT;
         end else begin
            x_in = xp + (yp >>> i);
            y_in = yp - (xp >>> i);
            z_in = zp + AT;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            x_ff[i]  <= x_in;
            y_ff[i]  <= y_in;
            z_ff[i]  <= z_in;
            nc_ff[i] <= ncp;
         end
      end
   end

   logic signed [CW-1:0] sin_ff, cos_ff, cos_in;

   assign cos_in = nc_ff[CORDIC_STEPS-1] ? -x_ff[CORDIC_STEPS-1] : x_ff[CORDIC_STEPS-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         sin_ff <= y_ff[CORDIC_STEPS-1];
         cos_ff <= cos_in;
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

`default_nettype wire

// ===== design/gcd_arc.sv =====
`default_nettype none

module gcd_arc (
   input  wire logic        clock,
   input  wire logic        adv,
   input  wire logic [30:0] a_in,
   output logic [57:0]      prod_out
);
   import gcd_pkg::*;

   // two integer square roots side by side: lane 0 of a, lane 1 of 1 - a
   logic [61:0] v_ff [0:1][0:SQRT_STEPS-1];
   logic [61:0] r_ff [0:1][0:SQRT_STEPS-1];
   logic [61:0] v_first [0:1];
   logic [30:0] a_rest;

   assign a_rest     = ONE_Q - a_in;
   assign v_first[0] = 62'(a_in) << FRAC_BITS;
   assign v_first[1] = 62'(a_rest) << FRAC_BITS;

   for (genvar l = 0; l < 2; l++) begin : g_lane
      for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
         localparam logic [61:0] BITV = 62'(1) << (2 * (SQRT_STEPS - 1 - j));
         logic [61:0] vp, rp, trial, v_in, r_in;

         if (j == 0) begin : g_first
            assign vp = v_first[l];
            assign rp = '0;
         end else begin : g_next
            assign vp = v_ff[l][j-1];
            assign rp = r_ff[l][j-1];
         end

         assign trial = rp + BITV;

         always_comb begin
            if (vp >= trial) begin
               v_in = vp - trial;
               r_in = (rp >> 1) + BITV;
            end else begin
               v_in = vp;
               r_in = rp >> 1;
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               v_ff[l][j] <= v_in;
               r_ff[l][j] <= r_in;
            end
         end
      end
   end

   // vectoring CORDIC on (sqrt(1-a), sqrt(a))
   logic signed [CW-1:0] x_ff [0:CORDIC_STEPS-1];
   logic signed [CW-1:0] y_ff [0:CORDIC_STEPS-1];
   logic signed [CW-1:0] z_ff [0:CORDIC_STEPS-1];

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
      localparam logic signed [CW-1:0] AT = atan_q(i);
      logic signed [CW-1:0] xp, yp, zp, x_in, y_in, z_in;

      if (i == 0) begin : g_first
         assign xp = $signed(r_ff[1][SQRT_STEPS-1][CW-1:0]);
         assign yp = $signed(r_ff[0][SQRT_STEPS-1][CW-1:0]);
         assign zp = '0;
      end else begin : g_next
         assign xp = x_ff[i-1];
         assign yp = y_ff[i-1];
         assign zp = z_ff[i-1];
      end

      always_comb begin
         if (!yp[CW-1]) begin
            x_in = xp + (yp >>> i);
            y_in = yp - (xp >>> i);
            z_in = zp + AT;
         end else begin
            x_in = xp - (yp >>> i);
            y_in = yp + (xp >>> i);
            z_in = zp - AT;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            x_ff[i] <= x_in;
            y_ff[i] <= y_in;
            z_ff[i] <= z_in;
         end
      end
   end

   // clamp a negative residue, scale by twice the radius
   logic [30:0] zc;
   logic [57:0] prod_ff, prod_in;

   assign zc      = z_ff[CORDIC_STEPS-1][CW-1] ? '0 : z_ff[CORDIC_STEPS-1][30:0];
   assign prod_in = 58'(zc) * 58'(SCALE_2R);

   always_ff @(posedge clock) begin
      if (adv) prod_ff <= prod_in;
   end

   assign prod_out = prod_ff;

endmodule

`default_nettype wire

// ===== design/great_circle_distance.sv =====
`default_nettype none

// channel   ports                                        dir  transfer
// req       req_valid req_stall req_lat_a req_lon_a      in   valid & !stall
//           req_lat_b req_lon_b
// rsp       rsp_valid rsp_stall rsp_distance_dm          out  valid & !stall
//
// One pair of positions enters per cycle while the pipe is not stalled; its
// distance passes through two input stages, four sin/cos lanes of 4 + 4
// divide + CORDIC_STEPS stages, four multiply stages, 31 square root
// stages, CORDIC_STEPS vectoring stages and two output stages.
// Reset clears only the valid bits. A stalled result freezes the whole pipe.

module great_circle_distance (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [30:0] req_lat_a,
   input  wire logic signed [31:0] req_lon_a,
   input  wire logic signed [30:0] req_lat_b,
   input  wire logic signed [31:0] req_lon_b,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [27:0]             rsp_distance_dm
);
   import gcd_pkg::*;

   logic adv;
   logic [PIPE_LAT-1:0] vld_ff, vld_in;

   assign adv       = !(vld_ff[PIPE_LAT-1] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[PIPE_LAT-1];
   assign vld_in    = {vld_ff[PIPE_LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset)    vld_ff <= '0;
      else if (adv) vld_ff <= vld_in;
   end

   // input register
   logic signed [30:0] lat_a_ff, lat_b_ff;
   logic signed [31:0] lon_a_ff, lon_b_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         lat_a_ff <= req_lat_a;
         lon_a_ff <= req_lon_a;
         lat_b_ff <= req_lat_b;
         lon_b_ff <= req_lon_b;
      end
   end

   // wrap to a full turn; latitudes doubled to half units
   logic signed [AW-1:0] dlat, dlon, lata, latb, dlat_w, dlon_w, lata_w, latb_w;
   logic [32:0] u_dlat_ff, u_dlon_ff, u_lata_ff, u_latb_ff;
   logic [32:0] u_dlat_in, u_dlon_in, u_lata_in, u_latb_in;

   always_comb begin
      dlat = AW'(lat_b_ff) - AW'(lat_a_ff);
      dlon = AW'(lon_b_ff) - AW'(lon_a_ff);
      lata = AW'(lat_a_ff);
      latb = AW'(lat_b_ff);

      dlat_w = dlat[AW-1] ? dlat + TURN_DEG7 : dlat;
      lata_w = lata[AW-1] ? lata + TURN_DEG7 : lata;
      latb_w = latb[AW-1] ? latb + TURN_DEG7 : latb;

      if (dlon < -TURN_DEG7)      dlon_w = dlon + TURN_HU;
      else if (dlon[AW-1])        dlon_w = dlon + TURN_DEG7;
      else if (dlon >= TURN_DEG7) dlon_w = dlon - TURN_DEG7;
      else                        dlon_w = dlon;

      u_dlat_in = dlat_w[32:0];
      u_dlon_in = dlon_w[32:0];
      u_lata_in = {lata_w[31:0], 1'b0};
      u_latb_in = {latb_w[31:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         u_dlat_ff <= u_dlat_in;
         u_dlon_ff <= u_dlon_in;
         u_lata_ff <= u_lata_in;
         u_latb_ff <= u_latb_in;
      end
   end

   logic signed [CW-1:0] sdl, sdo, ca, cb;

   gcd_sincos u_sc_dlat (.clock(clock), .adv(adv), .u_in(u_dlat_ff), .sin_out(sdl), .cos_out());
   gcd_sincos u_sc_dlon (.clock(clock), .adv(adv), .u_in(u_dlon_ff), .sin_out(sdo), .cos_out());
   gcd_sincos u_sc_lata (.clock(clock), .adv(adv), .u_in(u_lata_ff), .sin_out(), .cos_out(ca));
   gcd_sincos u_sc_latb (.clock(clock), .adv(adv), .u_in(u_latb_ff), .sin_out(), .cos_out(cb));

   // haversine term
   logic signed [63:0] p_cc_ff, p_dl_ff, p_do_ff, p_cc_in, p_dl_in, p_do_in;
   logic signed [CW-1:0] t_ff, sdl2_ff, sdo2_ff, t_in, sdl2_in, sdo2_in;
   logic signed [63:0] p_a_ff, p_a_in;
   logic signed [CW-1:0] sdl2_d_ff;
   logic signed [65:0] acc, a_sh;
   logic [30:0] a_ff, a_in;

   assign p_cc_in = $signed(ca[31:0]) * $signed(cb[31:0]);
   assign p_dl_in = $signed(sdl[31:0]) * $signed(sdl[31:0]);
   assign p_do_in = $signed(sdo[31:0]) * $signed(sdo[31:0]);

   assign t_in    = CW'((p_cc_ff + 64'sd536870912) >>> FRAC_BITS);
   assign sdl2_in = CW'((p_dl_ff + 64'sd536870912) >>> FRAC_BITS);
   assign sdo2_in = CW'((p_do_ff + 64'sd536870912) >>> FRAC_BITS);

   assign p_a_in = $signed(t_ff[31:0]) * $signed(sdo2_ff[31:0]);

   // rounding of the last product folded into the sum
   always_comb begin
      acc  = 66'(p_a_ff) + (66'(sdl2_d_ff) <<< FRAC_BITS) + 66'sd536870912;
      a_sh = acc >>> FRAC_BITS;
      if (a_sh[65])                    a_in = '0;
      else if (a_sh > 66'sd1073741824) a_in = ONE_Q;
      else                             a_in = a_sh[30:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_cc_ff   <= p_cc_in;
         p_dl_ff   <= p_dl_in;
         p_do_ff   <= p_do_in;
         t_ff      <= t_in;
         sdl2_ff   <= sdl2_in;
         sdo2_ff   <= sdo2_in;
         p_a_ff    <= p_a_in;
         sdl2_d_ff <= sdl2_ff;
         a_ff      <= a_in;
      end
   end

   logic [57:0] prod;

   gcd_arc u_arc (.clock(clock), .adv(adv), .a_in(a_ff), .prod_out(prod));

   // round to decimetres and saturate
   logic [58:0] rnd;
   logic [28:0] dq;
   logic [27:0] dist_ff, dist_in;

   always_comb begin
      rnd = 59'(prod) + 59'd536870912;
      dq  = rnd[58:30];
      if (dq > {1'b0, DIST_MAX}) dist_in = DIST_MAX;
      else                       dist_in = dq[27:0];
   end

   always_ff @(posedge clock) begin
      if (adv) dist_ff <= dist_in;
   end

   assign rsp_distance_dm = dist_ff;

endmodule

`default_nettype wire
